@@ hw/rtl/double_ended_queue_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/deq_pkg.sv @@
package deq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 2;
  localparam int unsigned StatW = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

endpackage

@@ hw/rtl/double_ended_queue_unit.sv @@
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    opcode_i, value_i
// out      out_valid_o / out_ready_i  status_o, count_o, is_empty_o, ends_valid_o,
//                                     front_value_o, rear_value_o
//
// Items pass one at a time: accept (pointer update and element write), read of both
// ends from the two-port element memory, then load of the output register.
// Reset clears pointers, count and handshake state; the element memory is not cleared.
// A stalled output holds the next item's read data until the output register frees up.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned IdxW = $clog2(CAPACITY),
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OpW-1:0]          opcode_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic [CntW-1:0]         count_o,
  output logic                    is_empty_o,
  output logic                    ends_valid_o,
  output logic signed [DataW-1:0] front_value_o,
  output logic signed [DataW-1:0] rear_value_o
);

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] i);
    ring_next = (i == IdxW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] i);
    ring_prev = (i == '0) ? IdxW'(CAPACITY - 1) : i - 1'b1;
  endfunction

  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  status_e         res_status_q, res_status_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [CntW-1:0]  out_count_q;
  logic [DataW-1:0] out_front_q;
  logic [DataW-1:0] out_rear_q;

  logic             accept;
  logic             load;
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic [DataW-1:0] rdata_a;
  logic [DataW-1:0] rdata_b;
  logic             full;
  logic             empty;
  op_e              op;

  assign op     = op_e'(opcode_i);
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign accept = in_valid_i && in_ready_o;
  assign load   = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = tail_q;
    if (accept) begin
      res_status_d = STAT_DONE;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (full) begin
            res_status_d = STAT_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + 1'b1;
            if (op == OP_PUSH_FRONT) begin
              head_d = ring_prev(head_q);
              waddr  = ring_prev(head_q);
            end else begin
              tail_d = ring_next(tail_q);
            end
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (empty) begin
            res_status_d = STAT_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
            if (op == OP_POP_FRONT) begin
              head_d = ring_next(head_q);
            end else begin
              tail_d = ring_prev(tail_q);
            end
          end
        end
        default: res_status_d = STAT_DONE;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      res_status_q <= STAT_DONE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      res_status_q <= res_status_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Count is stable from the accept until the next item, so load it here.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
      out_front_q  <= empty ? '0 : rdata_a;
      out_rear_q   <= empty ? '0 : rdata_b;
    end
  end

  deq_ram #(
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  ($unsigned(value_i)),
    .re_i     (state_q == ST_READ),
    .raddr_a_i(head_q),
    .raddr_b_i(ring_prev(tail_q)),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign count_o       = out_count_q;
  assign is_empty_o    = (out_count_q == '0);
  assign ends_valid_o  = (out_count_q != '0);
  assign front_value_o = $signed(out_front_q);
  assign rear_value_o  = $signed(out_rear_q);

endmodule

@@ hw/rtl/deq_ram.sv @@
module deq_ram
  import deq_pkg::*;
#(
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [DataW-1:0] rdata_a_o,
  output logic [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_a_q;
  logic [DataW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hw/rtl/deq_checker.sv @@
`include "double_ended_queue_unit_defines.svh"

module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [StatW-1:0]        status_o,
  input logic [CntW-1:0]         count_o,
  input logic                    is_empty_o,
  input logic                    ends_valid_o,
  input logic signed [DataW-1:0] front_value_o,
  input logic signed [DataW-1:0] rear_value_o
);

  `DEQ_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o) &&
      $stable(front_value_o) && $stable(rear_value_o),
    "stalled result changed")
  `DEQ_ASSERT(a_empty_ends,
    out_valid_o && is_empty_o |-> !ends_valid_o && front_value_o == 0 &&
      rear_value_o == 0,
    "empty deque shows ends")
  `DEQ_ASSERT(a_full_count,
    out_valid_o && status_o == STAT_FULL |-> count_o == CntW'(CAPACITY),
    "full push with room left")
  `DEQ_ASSERT(a_empty_count,
    out_valid_o && status_o == STAT_EMPTY |-> count_o == '0,
    "ignored pop with elements")
  `DEQ_ASSERT(a_one_elem,
    out_valid_o && count_o == CntW'(1) |-> front_value_o == rear_value_o,
    "single element ends differ")

endmodule

bind double_ended_queue_unit deq_checker #(.CAPACITY(CAPACITY)) u_deq_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned OPS_PER_PHASE = 345;

  typedef struct packed {
    op_e               op;
    logic signed [31:0] val;
  } deq_op_t;

  typedef struct packed {
    status_e            status;
    logic [4:0]         count;
    logic               is_empty;
    logic               ends_valid;
    logic signed [31:0] front;
    logic signed [31:0] rear;
  } deq_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [OpW-1:0]     opcode_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatW-1:0]   status_o;
  logic [4:0]         count_o;
  logic               is_empty_o;
  logic               ends_valid_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] rear_value_o;

  deq_op_t     pending_ops[$];
  deq_result_t expected_results[$];
  deq_op_t     next_op;
  deq_result_t want;
  deq_result_t got;

  // predicted deque contents
  logic signed [31:0] ring_mem [DEPTH];
  logic [3:0]         head_pos = '0;
  logic [3:0]         tail_pos = '0;
  logic [4:0]         live_cnt = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned ops_accepted = 0;
  int unsigned mismatch_cnt = 0;

  int unsigned idle_by_phase[4]  = '{0, 63, 0, 27};
  int unsigned stall_by_phase[4] = '{0, 0, 63, 27};

  double_ended_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .ends_valid_o  (ends_valid_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic predict_deque(input op_e op, input logic signed [31:0] val,
                               output deq_result_t r);
    logic [3:0] rear_pos;
    r = '0;
    r.status = STAT_DONE;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (live_cnt == DEPTH) begin
        r.status = STAT_FULL;
      end else if (op == OP_PUSH_FRONT) begin
        head_pos = head_pos - 4'd1;
        ring_mem[head_pos] = val;
        live_cnt = live_cnt + 5'd1;
      end else begin
        ring_mem[tail_pos] = val;
        tail_pos = tail_pos + 4'd1;
        live_cnt = live_cnt + 5'd1;
      end
    end else begin
      if (live_cnt == 0) begin
        r.status = STAT_EMPTY;
      end else if (op == OP_POP_FRONT) begin
        head_pos = head_pos + 4'd1;
        live_cnt = live_cnt - 5'd1;
      end else begin
        tail_pos = tail_pos - 4'd1;
        live_cnt = live_cnt - 5'd1;
      end
    end
    rear_pos = tail_pos - 4'd1;
    r.count = live_cnt;
    r.is_empty = (live_cnt == 0);
    r.ends_valid = (live_cnt != 0);
    r.front = (live_cnt != 0) ? ring_mem[head_pos] : '0;
    r.rear = (live_cnt != 0) ? ring_mem[rear_pos] : '0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(input op_e op, input logic signed [31:0] val);
    pending_ops.push_back('{op, val});
  endtask

  task automatic queue_directed_ops();
    logic signed [31:0] patterns[6];
    patterns = '{32'sh0, -32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA,
                 32'sh7FFF_FFFF, 32'sh8000_0000};
    // empty pops, then single element, then fill to full and overflow both ends
    add_op(OP_POP_FRONT, 32'sh1234_5678);
    add_op(OP_POP_REAR, -32'sd1);
    add_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    add_op(OP_PUSH_REAR, 32'sh8000_0000);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_REAR, '0);
    for (int i = 0; i < DEPTH; i++) begin
      add_op((i % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT,
             (i < 6) ? patterns[i] : pick_value());
    end
    add_op(OP_PUSH_FRONT, 32'sh0BAD_F00D);
    add_op(OP_PUSH_REAR, 32'sh7FFF_FFFF);
  endtask

  // Random walk in bursts that lean toward pushes, toward pops or neither, so the fill level
  // sweeps between empty and full.
  task automatic queue_random_ops(input int unsigned n);
    int unsigned bias;
    int unsigned run_len;
    op_e         op;
    bias = 50;
    run_len = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (run_len == 0) begin
        case ($urandom_range(2))
          0: bias = 85;
          1: bias = 15;
          default: bias = 50;
        endcase
        run_len = $urandom_range(40, 4);
      end
      run_len--;
      if ($urandom_range(99) < bias) begin
        op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
      end
      add_op(op, pick_value());
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // sender: hold the item until accepted, then maybe idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_op = pending_ops.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= next_op.op;
        value_i <= next_op.val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_deque(op_e'(opcode_i), value_i, want);
      expected_results.push_back(want);
      ops_accepted++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_e'(status_o), count_o, is_empty_o, ends_valid_o,
              front_value_o, rear_value_o};
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: unexpected item: status=%0d count=%0d", $realtime,
                   status_o, count_o);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch status %0d/%0d count %0d/%0d empty %0b/%0b",
                     $realtime, want.status, got.status, want.count, got.count,
                     want.is_empty, got.is_empty);
            $display("  ends_valid %0b/%0b front %0d/%0d rear %0d/%0d (exp/got)",
                     want.ends_valid, got.ends_valid, want.front, got.front,
                     want.rear, got.rear);
          end
        end
      end
    end
  end

  // Stall the output long enough that the block holds a result and drops in_ready_o.
  initial begin
    while (ops_accepted < 80) begin
      @(posedge clk_i);
    end
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (!rst_ni) begin
      @(posedge clk_i);
    end
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    queue_directed_ops();
    queue_random_ops(OPS_PER_PHASE);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 1; p < 4; p++) begin
      // pause the sender until every result is back
      wait_drained();
      @(negedge clk_i);
      send_idle_pct = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      queue_random_ops(OPS_PER_PHASE);
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/double_ended_queue_unit.sv
hw/rtl/deq_checker.sv
tb/tb.sv
